[design/qss_pkg.sv]
`default_nettype none

package qss_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = 4;
   localparam int NP_W       = 5;
   localparam int T_W        = 32;
   localparam int Q_W        = 48;
   localparam int LANES      = 4;
   localparam int STEPS      = 5;

   localparam logic signed [55:0] WIDE_MAX = 56'sd140737488355327;
   localparam logic signed [55:0] WIDE_MIN = -56'sd140737488355328;

   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSIDE = 2'd0,
      ST_BEFORE = 2'd1,
      ST_AFTER  = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   typedef logic [Q_W-1:0] q48_type;

   typedef struct packed {
      q48_type val;
      logic    sat;
   } satval_type;

   typedef struct packed {
      logic [T_W-1:0]  wp_time;
      q48_type [5:0]   coef;
   } row_type;

   // lane order: position, velocity, acceleration, jerk
   typedef struct packed {
      logic                          valid;
      logic [IDX_W-1:0]              seg;
      status_type                    region;
      logic                          flag;
      logic                          tneg;
      logic [T_W-1:0]                tmag;
      q48_type [LANES-1:0]           acc;
      q48_type [LANES-1:0][STEPS-1:0] coef;
   } step_type;

   function automatic satval_type sat48(logic signed [55:0] v);
      satval_type r;
      r.sat = 1'b0;
      r.val = v[Q_W-1:0];
      if (v > WIDE_MAX) begin
         r.sat = 1'b1;
         r.val = WIDE_MAX[Q_W-1:0];
      end else if (v < WIDE_MIN) begin
         r.sat = 1'b1;
         r.val = WIDE_MIN[Q_W-1:0];
      end
      return r;
   endfunction

   function automatic satval_type scale_sat(q48_type c, logic signed [7:0] k);
      logic signed [55:0] p;
      p = 56'($signed(c)) * 56'(k);
      return sat48(p);
   endfunction

endpackage

`default_nettype wire

[design/quintic_spline_sampler_core.sv]
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The pipeline has three front stages followed by five Horner steps of three stages each;
// the accepting edge loads the first front stage.
// Reset clears all valid bits and sets num_points to 2; the waypoint table is
// undefined until loaded.
`default_nettype none

module quintic_spline_sampler_core import qss_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // point_index, point_time, coef_c0..coef_c5, sample_time, zero pad
   input  wire logic [359:0] req_tdata,
   // cmd
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // position, velocity, acceleration, jerk, segment, status, zero pad
   output logic [199:0]      rsp_tdata,
   input  wire logic         csr_wen,
   input  wire logic [4:0]   csr_wdata
);

   logic                 adv, accept;
   logic [NP_W-1:0]      np_ff, n_eff;
   logic [IDX_W-1:0]     last_idx, pen_idx;
   logic [T_W-1:0]       time_ff [MAX_POINTS];
   row_type              mem [MAX_POINTS];
   row_type              wr_row;

   logic                 s1_valid_ff;
   logic [T_W-1:0]       s1_time_ff;
   logic [MAX_POINTS-1:0] ge, gt;
   logic [IDX_W-1:0]     seg_in;
   status_type           region_in;

   logic                 s2_valid_ff;
   logic [T_W-1:0]       s2_time_ff;
   logic [IDX_W-1:0]     s2_seg_ff;
   status_type           s2_region_ff;
   row_type              row_ff;

   step_type             s3_ff, s3_in;
   step_type             chain [STEPS+1];
   logic [32:0]          off;
   q48_type [LANES-1:0][5:0] k;
   satval_type           x2c2, x3c3, x4c4, x5c5, x6c3, x12c4, x20c5, x24c4, x60c5;
   status_type           st_out;

   assign rsp_tvalid = chain[STEPS].valid;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         np_ff <= NP_W'(2);
      end else if (csr_wen) begin
         np_ff <= csr_wdata;
      end
   end

   assign n_eff = (np_ff < NP_W'(2)) ? NP_W'(2) :
                  (np_ff > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : np_ff;
   assign last_idx = IDX_W'(n_eff - NP_W'(1));
   assign pen_idx  = IDX_W'(n_eff - NP_W'(2));

   always_comb begin
      wr_row.wp_time = req_tdata[35:4];
      for (int i = 0; i < 6; i++) begin
         wr_row.coef[i] = req_tdata[36 + 48*i +: 48];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cmd_type'(req_tuser) == CMD_LOAD) begin
         time_ff[req_tdata[3:0]] <= req_tdata[35:4];
         mem[req_tdata[3:0]]     <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept && cmd_type'(req_tuser) == CMD_SAMPLE;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_time_ff <= req_tdata[355:324];
      end
   end

   // locate segment
   always_comb begin
      for (int i = 0; i < MAX_POINTS; i++) begin
         ge[i] = s1_time_ff >= time_ff[i];
         gt[i] = s1_time_ff > time_ff[i];
      end
      seg_in    = '0;
      region_in = ST_INSIDE;
      priority if (!ge[0]) begin
         region_in = ST_BEFORE;
      end else if (gt[last_idx]) begin
         seg_in    = pen_idx;
         region_in = ST_AFTER;
      end else if (ge[pen_idx]) begin
         seg_in = pen_idx;
      end else begin
         for (int j = 0; j < MAX_POINTS - 2; j++) begin
            if ((NP_W'(j) + NP_W'(2) < n_eff) && ge[j] && !ge[j+1]) begin
               seg_in = IDX_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         row_ff <= mem[seg_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_time_ff   <= s1_time_ff;
         s2_seg_ff    <= seg_in;
         s2_region_ff <= region_in;
      end
   end

   // offset and derivative coefficients
   always_comb begin
      x2c2  = scale_sat(row_ff.coef[2], 8'sd2);
      x3c3  = scale_sat(row_ff.coef[3], 8'sd3);
      x4c4  = scale_sat(row_ff.coef[4], 8'sd4);
      x5c5  = scale_sat(row_ff.coef[5], 8'sd5);
      x6c3  = scale_sat(row_ff.coef[3], 8'sd6);
      x12c4 = scale_sat(row_ff.coef[4], 8'sd12);
      x20c5 = scale_sat(row_ff.coef[5], 8'sd20);
      x24c4 = scale_sat(row_ff.coef[4], 8'sd24);
      x60c5 = scale_sat(row_ff.coef[5], 8'sd60);

      k[0] = row_ff.coef;
      k[1] = {48'd0, x5c5.val, x4c4.val, x3c3.val, x2c2.val, row_ff.coef[1]};
      k[2] = {48'd0, 48'd0, x20c5.val, x12c4.val, x6c3.val, x2c2.val};
      k[3] = {48'd0, 48'd0, 48'd0, x60c5.val, x24c4.val, x6c3.val};

      off = {1'b0, s2_time_ff} - {1'b0, row_ff.wp_time};

      s3_in.valid  = s2_valid_ff;
      s3_in.seg    = s2_seg_ff;
      s3_in.region = s2_region_ff;
      if (s2_region_ff == ST_BEFORE) begin
         s3_in.flag = x2c2.sat | x6c3.sat;
         s3_in.tneg = 1'b0;
         s3_in.tmag = '0;
         s3_in.acc  = '0;
         s3_in.coef = '0;
         s3_in.coef[0][STEPS-1] = row_ff.coef[0];
         s3_in.coef[1][STEPS-1] = row_ff.coef[1];
         s3_in.coef[2][STEPS-1] = x2c2.val;
         s3_in.coef[3][STEPS-1] = x6c3.val;
      end else begin
         s3_in.flag = x2c2.sat | x3c3.sat | x4c4.sat | x5c5.sat | x6c3.sat
                    | x12c4.sat | x20c5.sat | x24c4.sat | x60c5.sat;
         s3_in.tneg = off[32];
         s3_in.tmag = off[32] ? 32'(-off) : off[31:0];
         for (int l = 0; l < LANES; l++) begin
            s3_in.acc[l] = k[l][5];
            for (int j = 0; j < STEPS; j++) begin
               s3_in.coef[l][j] = k[l][STEPS-1-j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
      end
   end

   assign chain[0] = s3_ff;

   for (genvar g = 0; g < STEPS; g++) begin : g_step
      qss_horner_step u_step (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step_in  (chain[g]),
         .step_out (chain[g+1])
      );
   end

   assign st_out = chain[STEPS].flag ? ST_SAT : chain[STEPS].region;
   assign rsp_tdata = {2'b00, st_out, chain[STEPS].seg, chain[STEPS].acc[3],
                       chain[STEPS].acc[2], chain[STEPS].acc[1], chain[STEPS].acc[0]};

`ifndef SYNTHESIS
   a_before_seg0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[197:196] == ST_BEFORE |-> rsp_tdata[195:192] == '0)
      else $error("before-start result not on segment 0");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[195:192] != 4'hF)
      else $error("segment out of range");

   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      accept && cmd_type'(req_tuser) == CMD_SAMPLE |=> s1_valid_ff)
      else $error("accepted sample item lost");
`endif

endmodule

`default_nettype wire

[design/qss_horner_step.sv]
`default_nettype none

module qss_horner_step import qss_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     adv,
   input  wire step_type step_in,
   output step_type      step_out
);

   step_type a_ff, a_in, b_ff, b_in, c_ff, c_in;

   logic [LANES-1:0][55:0] plo_ff, plo_in, phi_ff, phi_in;
   logic [LANES-1:0]       neg_ff, neg_in, ovf_in;
   logic [LANES-1:0][47:0] amag, mag_ff, mag_in;
   logic [LANES-1:0]       negb_ff;
   logic [LANES-1:0][79:0] psum;
   logic [LANES-1:0][63:0] rfull, lim;
   logic signed [48:0]     sval [LANES];
   logic signed [49:0]     csum [LANES];
   satval_type             sres [LANES];
   logic [LANES-1:0]       csat;

   // multiply magnitude by offset in two halves
   always_comb begin
      a_in = step_in;
      for (int l = 0; l < LANES; l++) begin
         amag[l]   = step_in.acc[l][Q_W-1] ? 48'(-step_in.acc[l]) : step_in.acc[l];
         plo_in[l] = 56'(amag[l][23:0]) * 56'(step_in.tmag);
         phi_in[l] = 56'(amag[l][47:24]) * 56'(step_in.tmag);
         neg_in[l] = step_in.acc[l][Q_W-1] ^ step_in.tneg;
      end
   end

   // combine, round half away from zero, clamp magnitude
   always_comb begin
      b_in = a_ff;
      for (int l = 0; l < LANES; l++) begin
         psum[l]   = {phi_ff[l], 24'd0} + 80'(plo_ff[l]) + 80'h8000;
         rfull[l]  = psum[l][79:16];
         lim[l]    = neg_ff[l] ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
         ovf_in[l] = rfull[l] > lim[l];
         mag_in[l] = ovf_in[l] ? lim[l][47:0] : rfull[l][47:0];
      end
      b_in.flag = a_ff.flag | (|ovf_in);
   end

   // apply sign, add coefficient, shift coefficients down
   always_comb begin
      c_in = b_ff;
      for (int l = 0; l < LANES; l++) begin
         sval[l] = negb_ff[l] ? -$signed({1'b0, mag_ff[l]}) : $signed({1'b0, mag_ff[l]});
         csum[l] = 50'(sval[l]) + 50'($signed(b_ff.coef[l][0]));
         sres[l] = sat48(56'(csum[l]));
         csat[l] = sres[l].sat;
         c_in.acc[l] = sres[l].val;
         for (int j = 0; j < STEPS; j++) begin
            c_in.coef[l][j] = (j < STEPS - 1) ? b_ff.coef[l][(j + 1) % STEPS] : '0;
         end
      end
      c_in.flag = b_ff.flag | (|csat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         neg_ff  <= neg_in;
         mag_ff  <= mag_in;
         negb_ff <= neg_ff;
      end
   end

   assign step_out = c_ff;

endmodule

`default_nettype wire

[tb/tb_quintic_spline_sampler_core.sv]
module tb_quintic_spline_sampler_core;
   import qss_pkg::*;

   localparam int  IDLE_LIMIT = 4000;
   localparam longint Q_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint Q_MIN = -64'sh8000_0000_0000;

   typedef struct {
      cmd_type     cmd;
      logic [3:0]  idx;
      logic [31:0] ptime;
      longint      c[6];
      logic [31:0] stime;
   } traj_item_type;

   typedef struct {
      logic [47:0] pos;
      logic [47:0] vel;
      logic [47:0] acc;
      logic [47:0] jrk;
      logic [3:0]  seg;
      status_type  st;
   } motion_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [359:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [199:0] rsp_tdata;
   logic         csr_wen;
   logic [4:0]   csr_wdata;

   logic [31:0]  wp_time[MAX_POINTS];
   longint       wp_coef[6][MAX_POINTS];
   logic [4:0]   num_pts;
   motion_type   pending_motion[$];
   int           fails;
   int           idle_cycles;
   bit           gaps_on;
   int           stall_left;

   quintic_spline_sampler_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 17) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint clamp_q(longint v, inout bit sat);
      if (v > Q_MAX) begin
         sat = 1'b1;
         return Q_MAX;
      end
      if (v < Q_MIN) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return v;
   endfunction

   function automatic longint scale_by_offset(longint a, bit tneg, logic [32:0] tmag,
                                              inout bit sat);
      bit            aneg;
      bit            neg;
      logic [127:0]  mag;
      logic [127:0]  prod;
      logic [127:0]  lim;
      aneg = a < 0;
      mag  = aneg ? 128'(-a) : 128'(a);
      neg  = aneg ^ tneg;
      prod = ((mag * 128'(tmag)) + 128'h8000) >> 16;
      lim  = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
      if (prod > lim) begin
         sat = 1'b1;
         return neg ? Q_MIN : Q_MAX;
      end
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint eval_poly(longint k[6], int deg, bit tneg, logic [32:0] tmag,
                                        inout bit sat);
      longint v;
      longint p;
      v = k[deg];
      for (int i = deg - 1; i >= 0; i--) begin
         p = scale_by_offset(v, tneg, tmag, sat);
         v = clamp_q(p + k[i], sat);
      end
      return v;
   endfunction

   function automatic bit eval_trajectory(traj_item_type it, output motion_type m);
      int          n;
      int          seg;
      status_type  st;
      longint      c[6];
      longint      pk[6];
      longint      vk[6];
      longint      ak[6];
      longint      jk[6];
      longint      r[4];
      longint      off;
      bit          sat;
      bit          tneg;
      logic [32:0] tmag;
      if (it.cmd == CMD_LOAD) begin
         wp_time[it.idx] = it.ptime;
         for (int i = 0; i < 6; i++) wp_coef[i][it.idx] = it.c[i];
         return 1'b0;
      end
      n = num_pts;
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      seg = 0;
      st  = ST_INSIDE;
      sat = 1'b0;
      if (it.stime < wp_time[0]) begin
         st = ST_BEFORE;
      end else if (it.stime > wp_time[n-1]) begin
         seg = n - 2;
         st  = ST_AFTER;
      end else if (it.stime >= wp_time[n-2]) begin
         seg = n - 2;
      end else begin
         for (int j = 0; j + 2 < n; j++)
            if (it.stime >= wp_time[j] && it.stime < wp_time[j+1]) seg = j;
      end
      for (int i = 0; i < 6; i++) c[i] = wp_coef[i][seg];
      if (st == ST_BEFORE) begin
         r[0] = c[0];
         r[1] = c[1];
         r[2] = clamp_q(2 * c[2], sat);
         r[3] = clamp_q(6 * c[3], sat);
      end else begin
         off  = longint'(it.stime) - longint'(wp_time[seg]);
         tneg = off < 0;
         tmag = tneg ? 33'(-off) : 33'(off);
         for (int i = 0; i < 6; i++) pk[i] = c[i];
         for (int i = 0; i < 5; i++) vk[i] = clamp_q((i + 1) * c[i+1], sat);
         vk[5] = 0;
         ak[0] = clamp_q(2 * c[2], sat);
         ak[1] = clamp_q(6 * c[3], sat);
         ak[2] = clamp_q(12 * c[4], sat);
         ak[3] = clamp_q(20 * c[5], sat);
         ak[4] = 0;
         ak[5] = 0;
         jk[0] = clamp_q(6 * c[3], sat);
         jk[1] = clamp_q(24 * c[4], sat);
         jk[2] = clamp_q(60 * c[5], sat);
         jk[3] = 0;
         jk[4] = 0;
         jk[5] = 0;
         r[0] = eval_poly(pk, 5, tneg, tmag, sat);
         r[1] = eval_poly(vk, 4, tneg, tmag, sat);
         r[2] = eval_poly(ak, 3, tneg, tmag, sat);
         r[3] = eval_poly(jk, 2, tneg, tmag, sat);
      end
      m.pos = r[0][47:0];
      m.vel = r[1][47:0];
      m.acc = r[2][47:0];
      m.jrk = r[3][47:0];
      m.seg = 4'(seg);
      m.st  = sat ? ST_SAT : st;
      return 1'b1;
   endfunction

   function automatic longint rand_coef();
      int     r;
      longint v;
      r = $urandom_range(0, 19);
      if (r == 0) return longint'($signed({$urandom, $urandom}) <<< 16) >>> 16;
      if (r == 1) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      v = longint'($urandom_range(0, 32'h03FF_FFFF));
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   task automatic send_item(traj_item_type it);
      motion_type m;
      int         g;
      g = gaps_on ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {4'b0, it.stime, it.c[5][47:0], it.c[4][47:0], it.c[3][47:0],
                     it.c[2][47:0], it.c[1][47:0], it.c[0][47:0], it.ptime, it.idx};
      do @(posedge clock); while (!req_tready);
      if (eval_trajectory(it, m)) pending_motion = {pending_motion, m};
   endtask

   task automatic load_entry(int idx, logic [31:0] t, longint c0, longint c1, longint c2,
                             longint c3, longint c4, longint c5);
      traj_item_type it;
      it.cmd   = CMD_LOAD;
      it.idx   = 4'(idx);
      it.ptime = t;
      it.c     = '{c0, c1, c2, c3, c4, c5};
      it.stime = $urandom;
      send_item(it);
   endtask

   task automatic sample_at(logic [31:0] t);
      traj_item_type it;
      it.cmd   = CMD_SAMPLE;
      it.idx   = 4'($urandom);
      it.ptime = $urandom;
      for (int i = 0; i < 6; i++) it.c[i] = rand_coef();
      it.stime = t;
      send_item(it);
   endtask

   task automatic drain_and_idle();
      req_tvalid <= 1'b0;
      while (pending_motion.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic set_num_points(logic [4:0] v);
      drain_and_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      num_pts = v;
   endtask

   task automatic test_directed_regions();
      set_num_points(5'd16);
      for (int i = 0; i < MAX_POINTS; i++)
         load_entry(i, 32'h0001_0000 * (i + 1), rand_coef(), rand_coef(), rand_coef(),
                    rand_coef(), rand_coef(), rand_coef());
      sample_at(32'h0000_0000);
      sample_at(32'h0001_0000);
      sample_at(32'h0003_8000);
      sample_at(32'h000F_0000);
      sample_at(32'h0010_0000);
      sample_at(32'h0010_4000);
      sample_at(32'hFFFF_FFFF);
   endtask

   task automatic test_saturation();
      set_num_points(5'd2);
      load_entry(0, 32'h0000_8000, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      load_entry(1, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0);
      sample_at(32'h0000_0000);
      sample_at(32'h0000_8000);
      sample_at(32'h8000_0000);
      sample_at(32'hFFFF_FFFF);
   endtask

   task automatic test_random_phase(logic [4:0] np, int count);
      bit          sorted;
      logic [31:0] t;
      longint      lo;
      longint      hi;
      longint      s;
      int          n;
      set_num_points(np);
      gaps_on = $urandom_range(0, 3) != 0;
      sorted  = $urandom_range(0, 4) != 0;
      t = $urandom_range(0, 32'h0004_0000);
      for (int i = 0; i < MAX_POINTS; i++) begin
         if (sorted) t = t + $urandom_range(1, 32'h0003_0000);
         else t = $urandom;
         load_entry(i, t, rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    rand_coef());
      end
      n = (np < 2) ? 2 : (np > MAX_POINTS) ? MAX_POINTS : np;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 6) == 0) begin
            load_entry($urandom_range(0, MAX_POINTS - 1),
                       sorted ? wp_time[$urandom_range(0, MAX_POINTS - 1)] : $urandom,
                       rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                       rand_coef());
         end else if ($urandom_range(0, 9) == 0) begin
            sample_at($urandom);
         end else begin
            lo = wp_time[0];
            hi = wp_time[n-1];
            if (hi < lo) begin
               s  = lo;
               lo = hi;
               hi = s;
            end
            lo = lo - 32'h0002_0000;
            hi = hi + 32'h0002_0000;
            if (lo < 0) lo = 0;
            if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
            s = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
            sample_at(s[31:0]);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= $urandom_range(0, 2) != 0;
         stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      motion_type m;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_motion.size() == 0) begin
            $error("result with no expectation: %h", rsp_tdata);
            fails++;
         end else begin
            m = pending_motion.pop_front();
            if (rsp_tdata[47:0] !== m.pos) begin
               $error("position expected %h got %h", m.pos, rsp_tdata[47:0]);
               fails++;
            end
            if (rsp_tdata[95:48] !== m.vel) begin
               $error("velocity expected %h got %h", m.vel, rsp_tdata[95:48]);
               fails++;
            end
            if (rsp_tdata[143:96] !== m.acc) begin
               $error("acceleration expected %h got %h", m.acc, rsp_tdata[143:96]);
               fails++;
            end
            if (rsp_tdata[191:144] !== m.jrk) begin
               $error("jerk expected %h got %h", m.jrk, rsp_tdata[191:144]);
               fails++;
            end
            if (rsp_tdata[195:192] !== m.seg) begin
               $error("segment expected %0d got %0d", m.seg, rsp_tdata[195:192]);
               fails++;
            end
            if (rsp_tdata[197:196] !== m.st) begin
               $error("status expected %0d got %0d", m.st, rsp_tdata[197:196]);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      fails       = 0;
      num_pts     = 5'd2;
      gaps_on     = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_LOAD;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_regions();
      test_saturation();
      test_random_phase(5'd2, 160);
      test_random_phase(5'd16, 160);
      test_random_phase(5'd0, 150);
      test_random_phase(5'd31, 150);
      test_random_phase(5'd1, 100);
      for (int p = 0; p < 6; p++) test_random_phase(5'($urandom_range(3, 15)), 160);
      drain_and_idle();
      if (fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
design/qss_pkg.sv
design/qss_horner_step.sv
design/quintic_spline_sampler_core.sv
tb/tb_quintic_spline_sampler_core.sv
